// ===== rtl/pifm_pkg.sv =====
// Shared types, constants and a helper function of the peak-interval frequency meter.
// No dependencies; every other file of the block uses it by scoped names.
package pifm_pkg;

  localparam int unsigned MAX_WINDOW  = 1024;
  localparam int unsigned IDX_W       = $clog2(MAX_WINDOW);
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned CNT_W       = $clog2(DATA_W);
  localparam int unsigned BCD_DIGITS  = 3;
  localparam int unsigned BCD_W       = 4 * BCD_DIGITS;
  localparam int unsigned SEG_W       = 8;

  localparam logic [DATA_W-1:0] RATE_RESET = DATA_W'(1000);
  localparam logic [SEG_W-1:0]  SEG_DP     = 8'h80;

  localparam int unsigned JOBQ_DEPTH = 2;
  localparam int unsigned JOBQ_PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int unsigned JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  // Peak tally codes
  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_ONE  = 2'd1;
  localparam logic [1:0] PK_TWO  = 2'd2;

  // One finished window, handed from the front to the back
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  period;
    logic [DATA_W-1:0] rate;
  } job_t;

  // Seven-segment code of one decimal digit, bit 0 is segment a
  function automatic logic [SEG_W-1:0] seg_encode(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/pifm_front.sv =====
// Front part: takes one sample per cycle while the job queue has room, finds the first two local
// peaks of a window and emits one job per window. Holds the sample_rate register. Depends on pifm_pkg.
module pifm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic                       q_full_i,
  input  logic [pifm_pkg::DATA_W-1:0] sample_value_i,
  input  logic                       last_i,
  input  logic                       cfg_we_i,
  input  logic [pifm_pkg::DATA_W-1:0] cfg_wdata_i,
  output logic                       job_push_o,
  output pifm_pkg::job_t             job_o
);

  logic [pifm_pkg::SAMPLE_BITS-1:0] cur;
  logic [pifm_pkg::SAMPLE_BITS-1:0] prev_q, pprev_q;
  logic [pifm_pkg::IDX_W-1:0]       idx_q, first_q, first_d, per_q, per_d, cand;
  logic [1:0]                       npk_q, npk_d;
  logic [pifm_pkg::DATA_W-1:0]      rate_q;
  logic                             accept, is_peak, end_win;

  assign cur    = sample_value_i[pifm_pkg::SAMPLE_BITS-1:0];
  assign accept = push_i && !q_full_i;
  assign cand   = idx_q - pifm_pkg::IDX_W'(1);

  // The previous sample is judged once its right neighbor is here
  assign is_peak = (idx_q >= pifm_pkg::IDX_W'(2)) && (prev_q > pprev_q) && (prev_q > cur);
  assign end_win = last_i || (idx_q == pifm_pkg::IDX_W'(pifm_pkg::MAX_WINDOW - 1));

  always_comb begin
    first_d = first_q;
    per_d   = per_q;
    npk_d   = npk_q;
    if (is_peak) begin
      if (npk_q == pifm_pkg::PK_NONE) begin
        first_d = cand;
        npk_d   = pifm_pkg::PK_ONE;
      end else if (npk_q == pifm_pkg::PK_ONE) begin
        per_d = cand - first_q;
        npk_d = pifm_pkg::PK_TWO;
      end
    end
  end

  assign job_push_o   = accept && end_win;
  assign job_o.valid  = (npk_d == pifm_pkg::PK_TWO) && (per_d != '0);
  assign job_o.period = per_d;
  assign job_o.rate   = rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      pprev_q <= '0;
      idx_q   <= '0;
      first_q <= '0;
      per_q   <= '0;
      npk_q   <= pifm_pkg::PK_NONE;
      rate_q  <= pifm_pkg::RATE_RESET;
    end else begin
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (end_win) begin
          prev_q  <= '0;
          pprev_q <= '0;
          idx_q   <= '0;
          first_q <= '0;
          per_q   <= '0;
          npk_q   <= pifm_pkg::PK_NONE;
        end else begin
          pprev_q <= prev_q;
          prev_q  <= cur;
          idx_q   <= idx_q + pifm_pkg::IDX_W'(1);
          first_q <= first_d;
          per_q   <= per_d;
          npk_q   <= npk_d;
        end
      end
    end
  end

  peak_tally_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (npk_q == pifm_pkg::PK_NONE) || (npk_q == pifm_pkg::PK_ONE) ||
    (npk_q == pifm_pkg::PK_TWO))
    else $error("peak tally out of range");

  second_peak_has_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (npk_q == pifm_pkg::PK_TWO) |-> (per_q != '0))
    else $error("second peak recorded with zero period");

  window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (npk_q != pifm_pkg::PK_NONE) |-> (first_q < idx_q))
    else $error("first peak index not behind current index");

endmodule

// ===== rtl/pifm_jobq.sv =====
// Short job queue between the front and the back of the meter.
// Register-based, depth from pifm_pkg::JOBQ_DEPTH. Depends on pifm_pkg.
module pifm_jobq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  pifm_pkg::job_t wdata_i,
  output logic           full_o,
  input  logic           rd_i,
  output pifm_pkg::job_t rdata_o,
  output logic           empty_o
);

  pifm_pkg::job_t                  mem_q [pifm_pkg::JOBQ_DEPTH];
  logic [pifm_pkg::JOBQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [pifm_pkg::JOBQ_CNT_W-1:0] cnt_q;
  logic                            do_wr, do_rd;

  assign full_o  = (cnt_q == pifm_pkg::JOBQ_CNT_W'(pifm_pkg::JOBQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  function automatic logic [pifm_pkg::JOBQ_PTR_W-1:0] ptr_inc(
    input logic [pifm_pkg::JOBQ_PTR_W-1:0] p);
    logic [pifm_pkg::JOBQ_PTR_W-1:0] n;
    if (p == pifm_pkg::JOBQ_PTR_W'(pifm_pkg::JOBQ_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + pifm_pkg::JOBQ_PTR_W'(1);
    end
    return n;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_rd) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + pifm_pkg::JOBQ_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - pifm_pkg::JOBQ_CNT_W'(1);
      end
    end
  end

  count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pifm_pkg::JOBQ_CNT_W'(pifm_pkg::JOBQ_DEPTH))
    else $error("job queue overfilled");

  empty_ptrs_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("job queue pointers disagree with count");

  write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i && !full_o && !rd_i) |=> (cnt_q == $past(cnt_q) + pifm_pkg::JOBQ_CNT_W'(1)))
    else $error("job queue write lost");

endmodule

// ===== rtl/pifm_back.sv =====
// Back part: divides sample_rate by the peak period, converts the quotient to three
// decimal digits and holds the result in an output register. Depends on pifm_pkg.
module pifm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pifm_pkg::job_t                job_i,
  input  logic                          q_empty_i,
  output logic                          q_pop_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [pifm_pkg::DATA_W-1:0]   frequency_o,
  output logic                          valid_res_o,
  output logic [pifm_pkg::SEG_W-1:0]    seg_hundreds_o,
  output logic [pifm_pkg::SEG_W-1:0]    seg_tens_o,
  output logic [pifm_pkg::SEG_W-1:0]    seg_ones_o
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_BCD, S_HOLD} state_e;

  state_e                         state_q;
  logic [pifm_pkg::CNT_W-1:0]     cnt_q;
  logic [pifm_pkg::DATA_W-1:0]    a_q, a_d, f_q;
  logic [pifm_pkg::IDX_W-1:0]     d_q, r_q, r_d;
  logic                           v_q;
  logic [pifm_pkg::BCD_W-1:0]     bcd_q, bcd_adj;
  logic [pifm_pkg::IDX_W:0]       sh;
  logic [pifm_pkg::IDX_W+1:0]     diff;
  logic                           out_full_q, last_step, out_load;

  logic [pifm_pkg::DATA_W-1:0]    freq_q;
  logic                           valid_q;
  logic [pifm_pkg::SEG_W-1:0]     seg_h_q, seg_t_q, seg_o_q;

  assign q_pop_o   = (state_q == S_IDLE) && !q_empty_i;
  assign last_step = (cnt_q == pifm_pkg::CNT_W'(pifm_pkg::DATA_W - 1));
  // Load the output register when it is free or being drained this cycle
  assign out_load  = (state_q == S_HOLD) && (!out_full_q || pop_i);

  // One restoring-division step: remainder stays below the divisor
  assign sh   = {r_q, a_q[pifm_pkg::DATA_W-1]};
  assign diff = {1'b0, sh} - {2'b00, d_q};

  always_comb begin
    if (!diff[pifm_pkg::IDX_W+1]) begin
      r_d = diff[pifm_pkg::IDX_W-1:0];
      a_d = {a_q[pifm_pkg::DATA_W-2:0], 1'b1};
    end else begin
      r_d = sh[pifm_pkg::IDX_W-1:0];
      a_d = {a_q[pifm_pkg::DATA_W-2:0], 1'b0};
    end
  end

  // Double-dabble correction per digit; carries past the top digit drop
  always_comb begin
    for (int k = 0; k < pifm_pkg::BCD_DIGITS; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      a_q        <= '0;
      f_q        <= '0;
      d_q        <= '0;
      r_q        <= '0;
      v_q        <= 1'b0;
      bcd_q      <= '0;
      out_full_q <= 1'b0;
      freq_q     <= '0;
      valid_q    <= 1'b0;
      seg_h_q    <= '0;
      seg_t_q    <= '0;
      seg_o_q    <= '0;
    end else begin
      if (out_load) begin
        out_full_q <= 1'b1;
      end else if (pop_i) begin
        out_full_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            a_q     <= job_i.rate;
            d_q     <= job_i.period;
            v_q     <= job_i.valid;
            r_q     <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          r_q <= r_d;
          if (last_step) begin
            // Invalid windows report zero
            a_q     <= v_q ? a_d : '0;
            f_q     <= v_q ? a_d : '0;
            bcd_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_BCD;
          end else begin
            a_q   <= a_d;
            cnt_q <= cnt_q + pifm_pkg::CNT_W'(1);
          end
        end
        S_BCD: begin
          bcd_q <= {bcd_adj[pifm_pkg::BCD_W-2:0], a_q[pifm_pkg::DATA_W-1]};
          a_q   <= {a_q[pifm_pkg::DATA_W-2:0], 1'b0};
          if (last_step) begin
            cnt_q   <= '0;
            state_q <= S_HOLD;
          end else begin
            cnt_q <= cnt_q + pifm_pkg::CNT_W'(1);
          end
        end
        S_HOLD: begin
          if (out_load) begin
            freq_q     <= f_q;
            valid_q    <= v_q;
            seg_h_q    <= pifm_pkg::seg_encode(bcd_q[11:8]);
            seg_t_q    <= pifm_pkg::seg_encode(bcd_q[7:4]);
            seg_o_q    <= pifm_pkg::seg_encode(bcd_q[3:0]) | pifm_pkg::SEG_DP;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign empty_o        = !out_full_q;
  assign frequency_o    = freq_q;
  assign valid_res_o    = valid_q;
  assign seg_hundreds_o = seg_h_q;
  assign seg_tens_o     = seg_t_q;
  assign seg_ones_o     = seg_o_q;

  hold_while_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD && out_full_q && !pop_i) |=> (state_q == S_HOLD))
    else $error("result dropped while output register occupied");

  invalid_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_full_q && !valid_q) |-> (freq_q == '0))
    else $error("invalid result carries nonzero frequency");

  idle_counter_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_HOLD) |-> (cnt_q == '0))
    else $error("step counter not cleared between jobs");

  pop_only_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == S_DIV))
    else $error("job taken without starting division");

endmodule

// ===== rtl/peak_interval_frequency_meter.sv =====
// Top level of the peak-interval frequency meter.
// Instantiates pifm_front, pifm_jobq and pifm_back; depends on pifm_pkg.
//
// Usage:
//   Samples enter through a queue-style port: a sample transfers on a rising edge
//   with push high and full low; last marks the final sample of a window, and the
//   MAX_WINDOW-th sample of a window closes it regardless of last.
//   Results leave through a queue-style port: while empty is low the oldest result
//   sits on frequency_o, valid_res_o and the seg_*_o ports; it transfers on a
//   rising edge with pop high and empty low.
//   sample_rate is written through cfg_we_i / cfg_wdata_i with no wait;
//   write it only while the block is idle.
// Timing:
//   Peak detection takes one sample per cycle while full is low. A closed window
//   becomes a job in a two-entry queue; the back unit picks up the job, runs a
//   bit-serial restoring division, then binary-to-BCD conversion, and then loads
//   the output register, waiting while that register is occupied. It takes no new
//   job until the result is loaded.
//   full rises only while both queue entries wait.
// Reset:
//   Clears the window state, empties the queue and output, and sets sample_rate
//   to 1000. When the receiver stalls, the result is held, the back unit parks
//   its next result, and samples keep flowing until the job queue fills.
module peak_interval_frequency_meter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [pifm_pkg::DATA_W-1:0]      sample_value_i,
  input  logic                             last_i,
  input  logic                             cfg_we_i,
  input  logic [pifm_pkg::DATA_W-1:0]      cfg_wdata_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [pifm_pkg::DATA_W-1:0]      frequency_o,
  output logic                             valid_res_o,
  output logic [pifm_pkg::SEG_W-1:0]       seg_hundreds_o,
  output logic [pifm_pkg::SEG_W-1:0]       seg_tens_o,
  output logic [pifm_pkg::SEG_W-1:0]       seg_ones_o
);

  pifm_pkg::job_t wjob, rjob;
  logic           job_push, q_full, q_empty, q_pop;

  // Stall sample intake only when no room is left for a finished window
  assign full = q_full;

  pifm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .q_full_i       (q_full),
    .sample_value_i (sample_value_i),
    .last_i         (last_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .job_push_o     (job_push),
    .job_o          (wjob)
  );

  // Decouple the streaming front from the multi-cycle back
  pifm_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_push),
    .wdata_i (wjob),
    .full_o  (q_full),
    .rd_i    (q_pop),
    .rdata_o (rjob),
    .empty_o (q_empty)
  );

  pifm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (rjob),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .frequency_o    (frequency_o),
    .valid_res_o    (valid_res_o),
    .seg_hundreds_o (seg_hundreds_o),
    .seg_tens_o     (seg_tens_o),
    .seg_ones_o     (seg_ones_o)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for peak_interval_frequency_meter: windows of samples in,
// one frequency reading per window out, each checked against an in-bench predictor.
// Depends on rtl/pifm_pkg.sv and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned RATE_AT_RESET = 1000;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned PHASE_BUDGET  = 155;     // short-window samples per phase

  // Segment codes of digits 0..9, digit d at bits [8*d +: 8]
  localparam logic [79:0] DIGIT_SEG = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                       8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

  typedef enum int {WAVE_NOISE, WAVE_FLAT, WAVE_SPIKES} wave_kind_e;

  typedef struct packed {
    logic [15:0] value;
    logic        lst;
  } sample_t;

  typedef struct packed {
    logic [15:0] freq;
    logic        ok;
    logic [7:0]  hund;
    logic [7:0]  tens;
    logic [7:0]  ones;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [15:0] sample_value_i = '0;
  logic last_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic full, empty, valid_res_o;
  logic [15:0] frequency_o;
  logic [7:0] seg_hundreds_o, seg_tens_o, seg_ones_o;

  sample_t  sample_q[$];    // samples waiting for the driver
  reading_t reading_q[$];   // readings predicted but not yet popped
  reading_t want_r;

  logic in_fire = 1'b0;     // a sample transferred at the last rising edge
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Predictor state: one window in flight plus the rate register
  logic [15:0] rate_hz = 16'(RATE_AT_RESET);
  logic [15:0] prev_s = '0;
  logic [15:0] prev2_s = '0;
  logic [10:0] win_idx = '0;
  logic [10:0] first_pk = '0;
  logic [1:0]  peak_cnt = pifm_pkg::PK_NONE;
  logic [10:0] span = '0;

  peak_interval_frequency_meter u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .sample_value_i (sample_value_i),
    .last_i         (last_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .empty          (empty),
    .pop            (pop),
    .frequency_o    (frequency_o),
    .valid_res_o    (valid_res_o),
    .seg_hundreds_o (seg_hundreds_o),
    .seg_tens_o     (seg_tens_o),
    .seg_ones_o     (seg_ones_o)
  );

  always #2 clk_i = ~clk_i;

  // Advance the window by one accepted sample; on the closing sample queue the
  // reading it produces and clear the window.
  task automatic track_sample(input logic [15:0] cur, input logic lst);
    logic closes;
    logic [15:0] hz;
    reading_t r;
    closes = lst;
    hz = '0;
    r = '0;
    // The previous sample can be judged now that its right neighbour is here.
    if (win_idx >= 2 && prev_s > prev2_s && prev_s > cur) begin
      if (peak_cnt == pifm_pkg::PK_NONE) begin
        first_pk = win_idx - 11'd1;
        peak_cnt = pifm_pkg::PK_ONE;
      end else if (peak_cnt == pifm_pkg::PK_ONE) begin
        span = win_idx - 11'd1 - first_pk;
        peak_cnt = pifm_pkg::PK_TWO;
      end
      // third and later peaks: drop
    end
    // A window that reaches the maximum length closes on its own.
    if (int'(win_idx) + 1 >= int'(pifm_pkg::MAX_WINDOW)) closes = 1'b1;
    if (!closes) begin
      prev2_s = prev_s;
      prev_s = cur;
      win_idx = win_idx + 11'd1;
    end else begin
      if (peak_cnt == pifm_pkg::PK_TWO && span != 0) begin
        hz = 16'(rate_hz / span);
        r.ok = 1'b1;
      end
      r.freq = hz;
      r.hund = DIGIT_SEG[8 * ((hz / 100) % 10) +: 8];
      r.tens = DIGIT_SEG[8 * ((hz / 10) % 10) +: 8];
      r.ones = DIGIT_SEG[8 * (hz % 10) +: 8] | pifm_pkg::SEG_DP;
      reading_q.push_back(r);
      prev_s = '0;
      prev2_s = '0;
      win_idx = '0;
      first_pk = '0;
      peak_cnt = pifm_pkg::PK_NONE;
      span = '0;
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatch_cnt++;
    end
  endtask

  // Sample both handshakes at the rising edge; predict on every sample
  // transfer, check on every result transfer.
  always @(posedge clk_i) begin
    in_fire <= push && !full;
    if (push && !full) begin
      sample_q.delete(0);
      track_sample(sample_value_i, last_i);
    end
    if (pop && !empty) begin
      if (reading_q.size() == 0) begin
        $display("%0t: unexpected result, frequency %h", $time, frequency_o);
        mismatch_cnt++;
      end else begin
        want_r = reading_q.pop_front();
        check_field("frequency", want_r.freq, frequency_o);
        check_field("valid_res", 16'(want_r.ok), 16'(valid_res_o));
        check_field("seg_hundreds", 16'(want_r.hund), 16'(seg_hundreds_o));
        check_field("seg_tens", 16'(want_r.tens), 16'(seg_tens_o));
        check_field("seg_ones", 16'(want_r.ones), 16'(seg_ones_o));
      end
    end
  end

  // Drive at the falling edge: hold an offered sample until it transfers, then
  // offer the next one unless this cycle is picked to idle. Stall pop at random.
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(0, 99) >= stall_pct);
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || in_fire) begin
      if (sample_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        push <= 1'b1;
        sample_value_i <= sample_q[0].value;
        last_i <= sample_q[0].lst;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Give up on a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic add_sample(input int unsigned v, input bit lst);
    sample_q.push_back('{value: 16'(v), lst: lst});
  endtask

  // Queue one window of len samples; close it with last only when asked.
  task automatic queue_window(input int unsigned len, input bit close);
    wave_kind_e kind;
    int unsigned pick, spacing, spot;
    int unsigned hi, lo, v;
    pick = $urandom_range(0, 9);
    kind = (pick < 2) ? WAVE_NOISE : (pick < 3) ? WAVE_FLAT : WAVE_SPIKES;
    spacing = $urandom_range(2, 12);
    spot = $urandom_range(0, spacing - 1);
    hi = $urandom_range(1, 65535);
    lo = $urandom_range(0, hi - 1);
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        WAVE_NOISE: v = $urandom_range(0, 65535);
        WAVE_FLAT:  v = $urandom_range(0, 3);
        default: begin
          v = (i % spacing == spot) ? hi : lo;
          // sprinkle some noise into the spike train
          if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 65535);
        end
      endcase
      add_sample(v, close && (i == len - 1));
    end
  endtask

  // Wait until every sample has gone in and every reading has come out, then
  // give the back unit time to go quiet.
  task automatic settle();
    while (sample_q.size() != 0 || reading_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    rate_hz = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned len, used;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed windows at the reset rate.
    add_sample(65535, 1);                        // one sample: no peak possible
    add_sample(65535, 0); add_sample(0, 1);      // two samples: still none
    add_sample(0, 0); add_sample(65535, 0);      // peaks at 1 and 3
    add_sample(0, 0); add_sample(65535, 0); add_sample(0, 1);
    add_sample(5, 0); add_sample(9, 0);          // plateau never counts,
    add_sample(9, 0); add_sample(5, 0);          // so only one peak
    add_sample(9, 0); add_sample(5, 1);
    add_sample(0, 0); add_sample(1, 0);          // three peaks: ignore the third
    add_sample(0, 0); add_sample(0, 0); add_sample(2, 0);
    add_sample(0, 0); add_sample(3, 0); add_sample(0, 1);
    settle();

    // Zero rate: a valid reading of zero hertz.
    write_rate(16'd0);
    add_sample(0, 0); add_sample(7, 0); add_sample(0, 0);
    add_sample(7, 0); add_sample(0, 1);
    settle();

    // Random phases, each with its own rate and idling mix.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;  stall_pct = 0;
          write_rate(16'hFFFF);
          // overlong window: closes itself, the tail forms a new window
          queue_window(pifm_pkg::MAX_WINDOW + 6, 1'b1);
        end
        1: begin
          idle_pct = 73; stall_pct = 0;
          write_rate(16'd1);
        end
        2: begin
          idle_pct = 0;  stall_pct = 73;
          write_rate(16'($urandom_range(1000, 65535)));
        end
        default: begin
          idle_pct = 35; stall_pct = 35;
          write_rate(16'($urandom_range(1, 65535)));
        end
      endcase
      used = 0;
      while (used < PHASE_BUDGET) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
        queue_window(len, 1'b1);
        used += len;
      end
      settle();
    end

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
